// ----- rtl/onewire_temperature_reader_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the 1-Wire temperature reader
// ---------------------------------------------------------------------------
`ifndef ONEWIRE_TEMPERATURE_READER_TOP_MACROS_SVH
`define ONEWIRE_TEMPERATURE_READER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset
`define OTR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Property checked in the cycle after its antecedent
`define OTR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define OTR_ASSERT(lbl, clk, rstn, prop, msg)
`define OTR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- rtl/otr_pkg.sv -----
// ---------------------------------------------------------------------------
// otr_pkg
// Types and constants shared by the 1-Wire temperature reader modules.
// ---------------------------------------------------------------------------
package otr_pkg;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_RLOW1  = 4'd1,
    PH_RWAIT1 = 4'd2,
    PH_RREC1  = 4'd3,
    PH_WR1    = 4'd4,
    PH_CONV   = 4'd5,
    PH_RLOW2  = 4'd6,
    PH_RWAIT2 = 4'd7,
    PH_RREC2  = 4'd8,
    PH_WR2    = 4'd9,
    PH_READ   = 4'd10
  } phase_e;

  // 1-Wire commands
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOT         = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_START   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CONV_WAIT    = 3'd5;
  localparam int unsigned CfgDataW = 20;

  // Register reset values
  localparam logic [9:0]  RST_RESET_LOW   = 10'd500;
  localparam logic [7:0]  RST_PRESENCE    = 8'd60;
  localparam logic [7:0]  RST_SLOT        = 8'd60;
  localparam logic [3:0]  RST_SLOT_START  = 4'd2;
  localparam logic [3:0]  RST_READ_SAMPLE = 4'd4;
  localparam logic [19:0] RST_CONV_WAIT   = 20'd0;

  typedef struct packed {
    logic [9:0]  reset_low_ticks;
    logic [7:0]  presence_sample_ticks;
    logic [7:0]  slot_ticks;
    logic [3:0]  slot_start_ticks;
    logic [3:0]  read_sample_ticks;
    logic [19:0] conversion_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  presence_missing;
    logic [6:0]  whole_degrees;
    logic [15:0] raw_reading;
  } result_t;

endpackage

// ----- rtl/otr_cfg.sv -----
// ---------------------------------------------------------------------------
// otr_cfg
// Timing configuration registers, written through the configuration channel.
// ---------------------------------------------------------------------------
module otr_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [otr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [otr_pkg::CfgDataW-1:0]      cfg_data_i,
  output otr_pkg::cfg_t                     cfg_o
);

  otr_pkg::cfg_t cfg_q, cfg_d;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        otr_pkg::CFG_RESET_LOW:   cfg_d.reset_low_ticks       = cfg_data_i[9:0];
        otr_pkg::CFG_PRESENCE:    cfg_d.presence_sample_ticks = cfg_data_i[7:0];
        otr_pkg::CFG_SLOT:        cfg_d.slot_ticks            = cfg_data_i[7:0];
        otr_pkg::CFG_SLOT_START:  cfg_d.slot_start_ticks      = cfg_data_i[3:0];
        otr_pkg::CFG_READ_SAMPLE: cfg_d.read_sample_ticks     = cfg_data_i[3:0];
        otr_pkg::CFG_CONV_WAIT:   cfg_d.conversion_wait_ticks = cfg_data_i[19:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the register values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks       <= otr_pkg::RST_RESET_LOW;
      cfg_q.presence_sample_ticks <= otr_pkg::RST_PRESENCE;
      cfg_q.slot_ticks            <= otr_pkg::RST_SLOT;
      cfg_q.slot_start_ticks      <= otr_pkg::RST_SLOT_START;
      cfg_q.read_sample_ticks     <= otr_pkg::RST_READ_SAMPLE;
      cfg_q.conversion_wait_ticks <= otr_pkg::RST_CONV_WAIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/otr_seq.sv -----
// ---------------------------------------------------------------------------
// otr_seq
// Measurement sequencer: advances one timing tick per accepted item.
// ---------------------------------------------------------------------------
`include "onewire_temperature_reader_top_macros.svh"

module otr_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             start_req_i,
  input  logic             line_level_i,
  input  otr_pkg::cfg_t    cfg_i,
  output otr_pkg::result_t res_o
);

  otr_pkg::phase_e phase_q, phase_d;
  logic [19:0] tick_q, tick_d;
  logic [2:0]  bit_q, bit_d;
  logic [2:0]  byte_q, byte_d;
  logic [7:0]  send_q, send_d;
  logic [15:0] recv_q, recv_d;
  logic [1:0]  flags_q, flags_d;

  logic        second;
  logic [8:0]  wr_end;
  logic [8:0]  rd_end;
  otr_pkg::result_t res;

  // Slot lengths
  assign wr_end = {5'b0, cfg_i.slot_start_ticks} + {1'b0, cfg_i.slot_ticks};
  assign rd_end = ({5'b0, cfg_i.read_sample_ticks} > wr_end) ?
                  {5'b0, cfg_i.read_sample_ticks} : wr_end;

  // Next state and tick result
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    send_d  = send_q;
    recv_d  = recv_q;
    flags_d = flags_q;
    res     = '0;
    res.busy_res = 1'b1;

    // Accept a start while idle
    if (phase_q == otr_pkg::PH_IDLE && start_req_i) begin
      phase_d = otr_pkg::PH_RLOW1;
      tick_d  = '0;
      flags_d = '0;
      recv_d  = '0;
      byte_d  = '0;
      bit_d   = '0;
    end
    second = (phase_d == otr_pkg::PH_RLOW2) || (phase_d == otr_pkg::PH_RWAIT2) ||
             (phase_d == otr_pkg::PH_RREC2) || (phase_d == otr_pkg::PH_WR2);

    unique case (phase_d)
      otr_pkg::PH_RLOW1, otr_pkg::PH_RLOW2: begin
        res.drive_low = 1'b1;
        tick_d = tick_d + 20'd1;
        if (tick_d >= {10'b0, cfg_i.reset_low_ticks}) begin
          tick_d  = '0;
          phase_d = second ? otr_pkg::PH_RWAIT2 : otr_pkg::PH_RWAIT1;
        end
      end
      otr_pkg::PH_RWAIT1, otr_pkg::PH_RWAIT2: begin
        tick_d = tick_d + 20'd1;
        if (tick_d >= {12'b0, cfg_i.presence_sample_ticks}) begin
          tick_d = '0;
          if (line_level_i) begin
            // No presence: flag it and skip the command writes
            flags_d = flags_d | (second ? 2'b10 : 2'b01);
            if (second) begin
              phase_d = otr_pkg::PH_READ;
              byte_d  = '0;
              bit_d   = '0;
            end else begin
              phase_d = otr_pkg::PH_RLOW2;
            end
          end else begin
            phase_d = second ? otr_pkg::PH_RREC2 : otr_pkg::PH_RREC1;
          end
        end
      end
      otr_pkg::PH_RREC1, otr_pkg::PH_RREC2: begin
        // Wait for the device to release the line, then send skip-ROM
        if (line_level_i) begin
          tick_d  = '0;
          phase_d = second ? otr_pkg::PH_WR2 : otr_pkg::PH_WR1;
          byte_d  = '0;
          send_d  = otr_pkg::CMD_SKIP_ROM;
          bit_d   = '0;
        end
      end
      otr_pkg::PH_WR1, otr_pkg::PH_WR2: begin
        if (tick_d < {16'b0, cfg_i.slot_start_ticks}) begin
          res.drive_low = 1'b1;
        end else if (tick_d < {11'b0, wr_end}) begin
          res.drive_low = ~send_d[0];
        end
        if (tick_d >= {11'b0, wr_end}) begin
          send_d = {1'b0, send_d[7:1]};
          if (bit_d == 3'd7) begin
            if (byte_d == 3'd0) begin
              // Second command byte of this stage
              byte_d = 3'd1;
              send_d = second ? otr_pkg::CMD_READ_SP : otr_pkg::CMD_CONVERT;
              bit_d  = '0;
              tick_d = '0;
            end else if (second) begin
              phase_d = otr_pkg::PH_READ;
              byte_d  = '0;
              bit_d   = '0;
              tick_d  = '0;
            end else begin
              tick_d  = '0;
              phase_d = (cfg_i.conversion_wait_ticks == 20'd0) ?
                        otr_pkg::PH_RLOW2 : otr_pkg::PH_CONV;
            end
          end else begin
            bit_d  = bit_d + 3'd1;
            tick_d = '0;
          end
        end else begin
          tick_d = tick_d + 20'd1;
        end
      end
      otr_pkg::PH_CONV: begin
        tick_d = tick_d + 20'd1;
        if (tick_d >= cfg_i.conversion_wait_ticks) begin
          tick_d  = '0;
          phase_d = otr_pkg::PH_RLOW2;
        end
      end
      otr_pkg::PH_READ: begin
        res.drive_low = (tick_d < {16'b0, cfg_i.slot_start_ticks});
        // Sample the read bit
        if (tick_d == {16'b0, cfg_i.read_sample_ticks} && line_level_i) begin
          recv_d[{byte_d[0], bit_d}] = 1'b1;
        end
        if (tick_d >= {11'b0, rd_end}) begin
          tick_d = '0;
          if (bit_d == 3'd7) begin
            bit_d = '0;
            if (byte_d >= 3'd1) begin
              res.done_res      = 1'b1;
              res.raw_reading   = recv_d;
              res.whole_degrees = {recv_d[10:8], recv_d[7:4]};
              phase_d = otr_pkg::PH_IDLE;
              byte_d  = '0;
            end else begin
              byte_d = 3'd1;
            end
          end else begin
            bit_d = bit_d + 3'd1;
          end
        end else begin
          tick_d = tick_d + 20'd1;
        end
      end
      default: begin
        phase_d      = otr_pkg::PH_IDLE;
        res.busy_res = 1'b0;
      end
    endcase
    res.presence_missing = flags_d;
  end

  // Advance the state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= otr_pkg::PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      send_q  <= '0;
      recv_q  <= '0;
      flags_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      send_q  <= send_d;
      recv_q  <= recv_d;
      flags_q <= flags_d;
    end
  end

  assign res_o = res;

  `OTR_ASSERT(a_done_busy, clk_i, rst_ni, !res.done_res || res.busy_res, "done outside a sequence")
  `OTR_ASSERT(a_reading_on_done, clk_i, rst_ni, res.done_res || (res.raw_reading == 16'd0 && res.whole_degrees == 7'd0), "reading shown without done")
  `OTR_ASSERT(a_idle_tick_clear, clk_i, rst_ni, phase_q != otr_pkg::PH_IDLE || tick_q == 20'd0, "tick counter not cleared in idle")
  `OTR_ASSERT_NEXT(a_hold_stalled, clk_i, rst_ni, !step_i, $stable(phase_q) && $stable(tick_q), "state moved without a tick")

endmodule

// ----- rtl/otr_out.sv -----
// ---------------------------------------------------------------------------
// otr_out
// Result register: holds one tick result until the output transfer.
// ---------------------------------------------------------------------------
module otr_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  otr_pkg::result_t res_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output otr_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  otr_pkg::result_t res_q;

  // Take a new result when empty or when the current one leaves
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/onewire_temperature_reader_top.sv -----
// Result: a tick's result is in the output register in the cycle after its input transfer.
// Throughput: one tick per cycle while the result register is empty or being taken; the
// sequencer state and the result register both advance on every input transfer.
// Reset: asynchronous, active low; sequencer idle with all counters and flags clear,
// configuration registers at their documented defaults, output register empty.
// ---------------------------------------------------------------------------
// onewire_temperature_reader_top
// 1-Wire master running one temperature measurement, one bus tick per item.
// ---------------------------------------------------------------------------
module onewire_temperature_reader_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [otr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [otr_pkg::CfgDataW-1:0] cfg_data_i,
  // Tick input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         start_req_i,
  input  logic                         line_level_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         drive_low_o,
  output logic                         busy_res_o,
  output logic                         done_res_o,
  output logic [1:0]                   presence_missing_o,
  output logic [6:0]                   whole_degrees_o,
  output logic [15:0]                  raw_reading_o
);

  otr_pkg::cfg_t    cfg;
  otr_pkg::result_t res_comb;
  otr_pkg::result_t res_reg;
  logic             step;

  // One tick per input transfer
  assign step = in_valid_i && in_ready_o;

  otr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  otr_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .start_req_i  (start_req_i),
    .line_level_i (line_level_i),
    .cfg_i        (cfg),
    .res_o        (res_comb)
  );

  otr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res_comb),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_reg)
  );

  // Unpack the result fields
  assign drive_low_o        = res_reg.drive_low;
  assign busy_res_o         = res_reg.busy_res;
  assign done_res_o         = res_reg.done_res;
  assign presence_missing_o = res_reg.presence_missing;
  assign whole_degrees_o    = res_reg.whole_degrees;
  assign raw_reading_o      = res_reg.raw_reading;

endmodule

// ----- bench/onewire_tick_checker.sv -----
// ---------------------------------------------------------------------------
// onewire_tick_checker
// Watches the tick, result and register channels of the 1-Wire reader. It
// keeps its own copy of the sequencer and the registers and works out the
// result of every accepted tick. It then compares each result transfer
// against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module onewire_tick_checker
  import otr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 start_req_i,
  input  logic                 line_level_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 drive_low_i,
  input  logic                 busy_res_i,
  input  logic                 done_res_i,
  input  logic [1:0]           presence_missing_i,
  input  logic [6:0]           whole_degrees_i,
  input  logic [15:0]          raw_reading_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow registers and sequencer state
  cfg_t        regs;
  phase_e      seq_phase;
  logic [19:0] seq_ticks;
  logic [2:0]  bit_pos;
  logic [2:0]  byte_pos;
  logic [7:0]  cmd_shift;
  logic [15:0] read_bits;
  logic [1:0]  no_presence;

  result_t     tick_results_q[$];
  int          errs;

  // Load a command byte into the write shifter
  function automatic void load_byte(logic [7:0] cmd);
    cmd_shift = cmd;
    bit_pos   = '0;
    seq_ticks = '0;
  endfunction

  // Enter the two-byte read
  function automatic void start_read();
    seq_phase = PH_READ;
    byte_pos  = '0;
    bit_pos   = '0;
    seq_ticks = '0;
  endfunction

  // Leave a reset stage: write commands, or skip them when nobody answered
  function automatic void finish_reset(logic second, logic missing);
    seq_ticks = '0;
    if (!missing) begin
      seq_phase = second ? PH_WR2 : PH_WR1;
      byte_pos  = '0;
      load_byte(CMD_SKIP_ROM);
    end else if (second) begin
      start_read();
    end else begin
      seq_phase = PH_RLOW2;
    end
  endfunction

  // Advance the sequencer by one tick and return what the block shows for it
  function automatic result_t predict_tick(logic start_req, logic line);
    result_t     r;
    logic        second;
    int unsigned slot_end;
    r          = '0;
    r.busy_res = 1'b1;

    if (seq_phase == PH_IDLE && start_req) begin
      seq_phase   = PH_RLOW1;
      seq_ticks   = '0;
      no_presence = '0;
      read_bits   = '0;
      byte_pos    = '0;
      bit_pos     = '0;
    end
    second = (seq_phase >= PH_RLOW2 && seq_phase <= PH_WR2);

    case (seq_phase)
      PH_RLOW1, PH_RLOW2: begin
        r.drive_low = 1'b1;
        seq_ticks++;
        if (seq_ticks >= regs.reset_low_ticks) begin
          seq_ticks = '0;
          seq_phase = second ? PH_RWAIT2 : PH_RWAIT1;
        end
      end
      PH_RWAIT1, PH_RWAIT2: begin
        seq_ticks++;
        if (seq_ticks >= regs.presence_sample_ticks) begin
          seq_ticks = '0;
          if (line) begin
            no_presence |= second ? 2'b10 : 2'b01;
            finish_reset(second, 1'b1);
          end else begin
            seq_phase = second ? PH_RREC2 : PH_RREC1;
          end
        end
      end
      PH_RREC1, PH_RREC2: begin
        if (line) finish_reset(second, 1'b0);
      end
      PH_WR1, PH_WR2: begin
        slot_end = regs.slot_start_ticks + regs.slot_ticks;
        if (seq_ticks < regs.slot_start_ticks) r.drive_low = 1'b1;
        else if (seq_ticks < slot_end) r.drive_low = ~cmd_shift[0];
        if (seq_ticks >= slot_end) begin
          cmd_shift = cmd_shift >> 1;
          if (bit_pos >= 3'd7) begin
            // Byte finished: next command, the read, or on to conversion
            if (byte_pos == '0) begin
              byte_pos = 3'd1;
              load_byte(second ? CMD_READ_SP : CMD_CONVERT);
            end else if (second) begin
              start_read();
            end else begin
              seq_ticks = '0;
              seq_phase = (regs.conversion_wait_ticks == '0) ? PH_RLOW2 : PH_CONV;
            end
          end else begin
            bit_pos++;
            seq_ticks = '0;
          end
        end else begin
          seq_ticks++;
        end
      end
      PH_CONV: begin
        seq_ticks++;
        if (seq_ticks >= regs.conversion_wait_ticks) begin
          seq_ticks = '0;
          seq_phase = PH_RLOW2;
        end
      end
      PH_READ: begin
        slot_end = regs.slot_start_ticks + regs.slot_ticks;
        if (regs.read_sample_ticks > slot_end) slot_end = regs.read_sample_ticks;
        r.drive_low = (seq_ticks < regs.slot_start_ticks);
        if (seq_ticks == regs.read_sample_ticks && line)
          read_bits[{byte_pos[0], bit_pos}] = 1'b1;
        if (seq_ticks >= slot_end) begin
          seq_ticks = '0;
          if (bit_pos >= 3'd7) begin
            bit_pos = '0;
            if (byte_pos >= 3'd1) begin
              r.done_res      = 1'b1;
              r.raw_reading   = read_bits;
              r.whole_degrees = {read_bits[10:8], read_bits[7:4]};
              seq_phase       = PH_IDLE;
              byte_pos        = '0;
            end else begin
              byte_pos = 3'd1;
            end
          end else begin
            bit_pos++;
          end
        end else begin
          seq_ticks++;
        end
      end
      default: begin
        seq_phase  = PH_IDLE;
        r.busy_res = 1'b0;
      end
    endcase

    r.presence_missing = no_presence;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endfunction

  // Track register writes, predict accepted ticks, compare result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      regs.reset_low_ticks       = RST_RESET_LOW;
      regs.presence_sample_ticks = RST_PRESENCE;
      regs.slot_ticks            = RST_SLOT;
      regs.slot_start_ticks      = RST_SLOT_START;
      regs.read_sample_ticks     = RST_READ_SAMPLE;
      regs.conversion_wait_ticks = RST_CONV_WAIT;
      seq_phase   = PH_IDLE;
      seq_ticks   = '0;
      bit_pos     = '0;
      byte_pos    = '0;
      cmd_shift   = '0;
      read_bits   = '0;
      no_presence = '0;
      tick_results_q.delete();
      errs = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RESET_LOW:   regs.reset_low_ticks       = cfg_data_i[9:0];
          CFG_PRESENCE:    regs.presence_sample_ticks = cfg_data_i[7:0];
          CFG_SLOT:        regs.slot_ticks            = cfg_data_i[7:0];
          CFG_SLOT_START:  regs.slot_start_ticks      = cfg_data_i[3:0];
          CFG_READ_SAMPLE: regs.read_sample_ticks     = cfg_data_i[3:0];
          CFG_CONV_WAIT:   regs.conversion_wait_ticks = cfg_data_i;
          default: ;
        endcase
      end

      // Compare before pushing: a result never leaves in its own tick's cycle
      if (out_valid_i && out_ready_i) begin
        if (tick_results_q.size() == 0) begin
          $error("result transfer with no tick outstanding");
          errs++;
        end else begin
          want = tick_results_q.pop_front();
          check_field("drive_low", want.drive_low, drive_low_i);
          check_field("busy_res", want.busy_res, busy_res_i);
          check_field("done_res", want.done_res, done_res_i);
          check_field("presence_missing", want.presence_missing, presence_missing_i);
          check_field("whole_degrees", want.whole_degrees, whole_degrees_i);
          check_field("raw_reading", want.raw_reading, raw_reading_i);
        end
      end

      if (in_valid_i && in_ready_i)
        tick_results_q.push_back(predict_tick(start_req_i, line_level_i));

      fail_count_o <= errs;
      pending_o    <= tick_results_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Drives the 1-Wire temperature reader with bus ticks under a series of
// register settings, from the smallest timings to the largest, with random
// bus levels and start requests and with both sides idling at random.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import otr_pkg::*;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int PHASES         = 10;
  localparam int ITEMS_PER_PHASE = 83;
  localparam int HOLD_CYCLES    = 100;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                start_req_i  = 1'b0;
  logic                line_level_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic                drive_low_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic [1:0]          presence_missing_o;
  logic [6:0]          whole_degrees_o;
  logic [15:0]         raw_reading_o;

  int    fail_count;
  int    pending;
  int    gap_pct   = 0;
  int    stall_pct = 0;
  logic  hold_req  = 1'b0;
  longint cycle_count = 0;

  onewire_temperature_reader_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .start_req_i        (start_req_i),
    .line_level_i       (line_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .drive_low_o        (drive_low_o),
    .busy_res_o         (busy_res_o),
    .done_res_o         (done_res_o),
    .presence_missing_o (presence_missing_o),
    .whole_degrees_o    (whole_degrees_o),
    .raw_reading_o      (raw_reading_o)
  );

  onewire_tick_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .start_req_i        (start_req_i),
    .line_level_i       (line_level_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .drive_low_i        (drive_low_o),
    .busy_res_i         (busy_res_o),
    .done_res_i         (done_res_o),
    .presence_missing_i (presence_missing_o),
    .whole_degrees_i    (whole_degrees_o),
    .raw_reading_i      (raw_reading_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off to back the block up
  initial begin
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one tick, with random idle cycles ahead of it; return on transfer
  task automatic put_tick(input logic start_req, input logic line);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    start_req_i  <= start_req;
    line_level_i <= line;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold a register write until it transfers; caller drops valid afterwards
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_regs(input int unsigned reset_low, input int unsigned presence,
                          input int unsigned slot, input int unsigned slot_start,
                          input int unsigned read_sample, input int unsigned conv_wait);
    write_reg(CFG_RESET_LOW, CfgDataW'(reset_low));
    write_reg(CFG_PRESENCE, CfgDataW'(presence));
    write_reg(CFG_SLOT, CfgDataW'(slot));
    write_reg(CFG_SLOT_START, CfgDataW'(slot_start));
    write_reg(CFG_READ_SAMPLE, CfgDataW'(read_sample));
    write_reg(CFG_CONV_WAIT, CfgDataW'(conv_wait));
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int k;
    int n;
    int mode;
    int line_pct;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero reset and presence counts act as one, sample inside
    // the opening pulse, start while busy, presence then stuck-low recovery
    set_regs(0, 0, 1, 2, 1, 0);
    put_tick(1'b0, 1'b0);
    put_tick(1'b0, 1'b1);
    put_tick(1'b1, 1'b0);
    put_tick(1'b1, 1'b0);
    repeat (3) put_tick(1'b0, 1'b0);
    put_tick(1'b1, 1'b1);
    repeat (14) put_tick($urandom_range(0, 3) == 0, $urandom_range(0, 99) < 50);
    drain();

    // Random phases, each under its own register setting and idling mode
    for (k = 0; k < PHASES; k++) begin
      mode = k % 4;
      gap_pct   <= (mode == 1) ? 68 : (mode == 3) ? 20 : 0;
      stall_pct <= (mode == 2) ? 68 : (mode == 3) ? 20 : 0;
      if (k == 4) hold_req <= 1'b1;
      case (k)
        0: set_regs(1, 1, 1, 1, 1, 0);
        1: begin
          write_reg(CFG_UNUSED, CfgDataW'($urandom));
          set_regs(0, 0, 0, 0, 0, 0);
        end
        2: set_regs(1, 1, 2, 15, 3, 3);
        3: set_regs(1023, 255, 255, 15, 15, 1048575);
        default: set_regs($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 3), $urandom_range(0, 6),
                          ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      endcase
      line_pct = 25 * $urandom_range(1, 3);
      for (n = 0; n < ITEMS_PER_PHASE; n++)
        put_tick($urandom_range(0, 3) == 0, $urandom_range(0, 99) < line_pct);
      drain();
    end

    // Let any stray result show up before the verdict
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
